// ===== rtl/dpq_pkg.sv =====
// shared types and constants for the double-ended priority queue
package dpq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MAX = 2'd1,
    OP_DEL_MIN = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_HOLD = 2'd2
  } state_e;

  // command broadcast to every cell of the sorted chain
  typedef struct packed {
    logic  insert;
    logic  remove;
    logic  shift_down;
    data_t value;
  } cell_cmd_t;

endpackage

// ===== rtl/dpq_cell.sv =====
// one cell of the sorted register chain: holds one value and its valid bit
module dpq_cell (
  input  logic              clk,
  input  logic              rst,
  input  dpq_pkg::cell_cmd_t cmd,
  input  dpq_pkg::data_t    lo_val,
  input  logic              lo_gt,
  input  logic              lo_vld,
  input  dpq_pkg::data_t    up_val,
  input  logic              up_vld,
  output dpq_pkg::data_t    val,
  output logic              vld,
  output logic              gt
);

  dpq_pkg::data_t val_next;
  logic           vld_next;

  // empty cells count as larger than anything
  assign gt = !vld || (val > cmd.value);

  always_comb begin
    val_next = val;
    vld_next = vld;
    if (cmd.insert) begin
      if (gt) begin
        val_next = lo_gt ? lo_val : cmd.value;
      end
      vld_next = vld || lo_vld;
    end else if (cmd.remove) begin
      vld_next = vld && up_vld;
      if (cmd.shift_down) begin
        val_next = up_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

endmodule

// ===== rtl/double_ended_priority_queue_unit.sv =====
// top level: double-ended priority queue built on a sorted chain of cells
// an accepted input beat updates the cell registers, and in the EVAL state the result is registered
// into the output registers; a new beat is accepted only once the previous result is taken; each cell
// compares and shifts in place, and EVAL then reads the top of the chain into the output register
// reset clears all cell valid bits and the handshake state; stored values are not cleared
// an insert into a full chain is dropped and flagged
module double_ended_priority_queue_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic signed [31:0]    value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    max_value,
  output logic signed [31:0]    min_value,
  output logic                  is_empty,
  output logic                  insert_dropped
);

  dpq_pkg::state_e    state;
  dpq_pkg::state_e    state_next;
  dpq_pkg::cell_cmd_t cmd;
  dpq_pkg::data_t     cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_vld;
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_top;
  dpq_pkg::data_t     top_val;
  logic               accept;
  logic               full;
  logic               drop_q;

  assign accept = in_valid && in_ready;
  assign full   = cell_vld[CAPACITY-1];

  always_comb begin
    cmd.insert     = 1'b0;
    cmd.remove     = 1'b0;
    cmd.shift_down = 1'b0;
    cmd.value      = value;
    if (accept) begin
      unique case (operation)
        dpq_pkg::OP_INSERT:  cmd.insert = !full;
        dpq_pkg::OP_DEL_MAX: cmd.remove = 1'b1;
        dpq_pkg::OP_DEL_MIN: begin
          cmd.remove     = 1'b1;
          cmd.shift_down = 1'b1;
        end
        default: cmd.remove = 1'b0;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dpq_pkg::data_t lo_val;
    dpq_pkg::data_t up_val;
    logic           lo_gt;
    logic           lo_vld;
    logic           up_vld;
    if (i == 0) begin : g_lo_edge
      assign lo_val = cell_val[i];
      assign lo_gt  = 1'b0;
      assign lo_vld = 1'b1;
    end else begin : g_lo_link
      assign lo_val = cell_val[i-1];
      assign lo_gt  = cell_gt[i-1];
      assign lo_vld = cell_vld[i-1];
    end
    if (i == CAPACITY - 1) begin : g_up_edge
      assign up_val = cell_val[i];
      assign up_vld = 1'b0;
    end else begin : g_up_link
      assign up_val = cell_val[i+1];
      assign up_vld = cell_vld[i+1];
    end
    dpq_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .lo_val (lo_val),
      .lo_gt  (lo_gt),
      .lo_vld (lo_vld),
      .up_val (up_val),
      .up_vld (up_vld),
      .val    (cell_val[i]),
      .vld    (cell_vld[i]),
      .gt     (cell_gt[i])
    );
  end

  // top of the thermometer holds the maximum
  assign cell_top = cell_vld & ~(cell_vld >> 1);

  always_comb begin
    top_val = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (cell_top[i]) begin
        top_val = top_val | cell_val[i];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dpq_pkg::ST_IDLE: if (in_valid) state_next = dpq_pkg::ST_EVAL;
      dpq_pkg::ST_EVAL: state_next = dpq_pkg::ST_HOLD;
      dpq_pkg::ST_HOLD: begin
        if (out_ready) begin
          state_next = in_valid ? dpq_pkg::ST_EVAL : dpq_pkg::ST_IDLE;
        end
      end
      default: state_next = dpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == dpq_pkg::ST_IDLE) || ((state == dpq_pkg::ST_HOLD) && out_ready);
    out_valid = (state == dpq_pkg::ST_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drop_q <= (operation == dpq_pkg::OP_INSERT) && full;
    end
    if (state == dpq_pkg::ST_EVAL) begin
      max_value      <= top_val;
      min_value      <= cell_vld[0] ? cell_val[0] : '0;
      is_empty       <= !cell_vld[0];
      insert_dropped <= drop_q;
    end
  end

`ifndef SYNTH
  a_thermometer: assert property (@(posedge clk) disable iff (rst)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("cell valid bits not contiguous");

  a_result_delayed: assert property (@(posedge clk) disable iff (rst)
    accept |=> !out_valid)
    else $error("result shown before evaluation");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (max_value == '0 && min_value == '0))
    else $error("empty result with nonzero values");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_empty) |-> (min_value <= max_value))
    else $error("minimum above maximum");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == dpq_pkg::OP_INSERT && full) |=> ##1 insert_dropped)
    else $error("full insert not flagged");
`endif

endmodule
